/* sv/i2cm_pkg.sv */
// Package: shared types, codes and constants for the I2C master register access core.
`default_nettype none
package i2cm_pkg;

    // Field and register widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PHASE_W  = 10;
    localparam int unsigned ACKTO_W  = 8;
    localparam int unsigned BITCNT_W = 4;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned CFGIDX_W = 1;
    localparam int unsigned CFGDAT_W = 10;

    // Configuration reset values
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = PHASE_W'(60);
    localparam logic [ACKTO_W-1:0] ACK_TIMEOUT_RST = ACKTO_W'(240);

    // Configuration register indexes
    localparam logic [CFGIDX_W-1:0] CFG_PHASE_TICKS = 1'b0;
    localparam logic [CFGIDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Byte stages of a transaction
    localparam logic [1:0] STAGE_ADDR = 2'd0;
    localparam logic [1:0] STAGE_REG  = 2'd1;
    localparam logic [1:0] STAGE_DATA = 2'd2;

    // Completion status codes
    localparam logic [STAT_W-1:0] STATUS_OK = 2'd0;

    // Address masks
    localparam logic [BYTE_W-1:0] ADDR_WR_MASK = 8'hfe;
    localparam logic [BYTE_W-1:0] ADDR_RD_BIT  = 8'h01;

    // Bits per byte on the bus
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [BITCNT_W-1:0] LAST_BIT      = 4'd7;

    // Bus sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'd0,
        ST_S1   = 5'd1,
        ST_S2   = 5'd2,
        ST_S3   = 5'd3,
        ST_B1   = 5'd4,
        ST_B2   = 5'd5,
        ST_B3   = 5'd6,
        ST_A1   = 5'd7,
        ST_A2   = 5'd8,
        ST_AW   = 5'd9,
        ST_A3   = 5'd10,
        ST_R1   = 5'd11,
        ST_R2   = 5'd12,
        ST_K1   = 5'd13,
        ST_K2   = 5'd14,
        ST_K3   = 5'd15,
        ST_P0   = 5'd16,
        ST_P1   = 5'd17
    } t_seq_state;

    // One input item
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] read_len;
        logic              sda_in;
    } t_item;

    // One result item
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_data;
        logic              rx_last;
        logic              done_res;
        logic [STAT_W-1:0] status;
    } t_result;

    // Configuration register values
    typedef struct packed {
        logic [PHASE_W-1:0] phase_ticks;
        logic [ACKTO_W-1:0] ack_timeout;
    } t_cfg;

endpackage
`default_nettype wire

/* sv/i2cm_seq.sv */
// Bus sequencer: state registers and the single-step logic for one tick item.
`default_nettype none
module i2cm_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire i2cm_pkg::t_item i_item,
    input  wire i2cm_pkg::t_cfg  i_cfg,
    output i2cm_pkg::t_result    o_res
);

    i2cm_pkg::t_seq_state r_state, n_state;
    logic [i2cm_pkg::PHASE_W-1:0]  r_phase_count, n_phase_count;
    logic [i2cm_pkg::BITCNT_W-1:0] r_bit_count, n_bit_count;
    logic [i2cm_pkg::BYTE_W-1:0]   r_shift, n_shift;
    logic [i2cm_pkg::BYTE_W-1:0]   r_bytes_left, n_bytes_left;
    logic [i2cm_pkg::ACKTO_W-1:0]  r_ack_wait, n_ack_wait;
    logic [i2cm_pkg::BYTE_W-1:0]   r_held_addr, n_held_addr;
    logic [i2cm_pkg::BYTE_W-1:0]   r_held_reg, n_held_reg;
    logic [i2cm_pkg::BYTE_W-1:0]   r_held_wdata, n_held_wdata;
    logic                          r_is_read, n_is_read;
    logic [i2cm_pkg::STAT_W-1:0]   r_held_status, n_held_status;
    logic [1:0]                    r_byte_stage, n_byte_stage;
    logic                          r_scl, n_scl;
    logic                          r_sda, n_sda;

    logic [i2cm_pkg::PHASE_W-1:0]  phase_inc;
    logic                          phase_hit;
    logic [i2cm_pkg::BITCNT_W-1:0] bit_inc;
    logic [i2cm_pkg::BYTE_W-1:0]   bytes_dec;
    logic                          is_cmd;
    logic                          ack_low;
    logic                          ack_expired;
    logic                          timed;

    // Pick the byte to send for a given stage
    function automatic logic [i2cm_pkg::BYTE_W-1:0] tx_byte(
        input logic [1:0]                  stage,
        input logic                        rd,
        input logic [i2cm_pkg::BYTE_W-1:0] addr,
        input logic [i2cm_pkg::BYTE_W-1:0] regn,
        input logic [i2cm_pkg::BYTE_W-1:0] wdata
    );
        logic [i2cm_pkg::BYTE_W-1:0] b;
        case (stage)
            i2cm_pkg::STAGE_ADDR: b = addr & i2cm_pkg::ADDR_WR_MASK;
            i2cm_pkg::STAGE_REG:  b = regn;
            default:              b = rd ? (addr | i2cm_pkg::ADDR_RD_BIT) : wdata;
        endcase
        return b;
    endfunction

    // Shared step terms
    assign phase_inc   = r_phase_count + i2cm_pkg::PHASE_W'(1);
    assign phase_hit   = phase_inc >= i_cfg.phase_ticks;
    assign bit_inc     = r_bit_count + i2cm_pkg::BITCNT_W'(1);
    assign bytes_dec   = r_bytes_left - i2cm_pkg::BYTE_W'(1);
    assign is_cmd      = (i_item.mode == i2cm_pkg::MODE_WRITE) ||
                         (i_item.mode == i2cm_pkg::MODE_READ);
    assign ack_low     = !i_item.sda_in;
    assign ack_expired = r_ack_wait >= i_cfg.ack_timeout;
    assign timed       = (r_state != i2cm_pkg::ST_IDLE) && (r_state != i2cm_pkg::ST_AW);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2cm_pkg::ST_IDLE: if (is_cmd) n_state = i2cm_pkg::ST_S1;
            i2cm_pkg::ST_AW:   if (ack_low || ack_expired) n_state = i2cm_pkg::ST_A3;
            default: begin
                if (phase_hit) begin
                    case (r_state)
                        i2cm_pkg::ST_S1: n_state = i2cm_pkg::ST_S2;
                        i2cm_pkg::ST_S2: n_state = i2cm_pkg::ST_S3;
                        i2cm_pkg::ST_S3: n_state = i2cm_pkg::ST_B1;
                        i2cm_pkg::ST_B1: n_state = i2cm_pkg::ST_B2;
                        i2cm_pkg::ST_B2: n_state = i2cm_pkg::ST_B3;
                        i2cm_pkg::ST_B3: n_state = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                                                   i2cm_pkg::ST_A1 : i2cm_pkg::ST_B1;
                        i2cm_pkg::ST_A1: n_state = i2cm_pkg::ST_A2;
                        i2cm_pkg::ST_A2: n_state = i2cm_pkg::ST_AW;
                        i2cm_pkg::ST_A3: begin
                            if (r_held_status != i2cm_pkg::STATUS_OK)
                                n_state = i2cm_pkg::ST_P0;
                            else if (r_byte_stage == i2cm_pkg::STAGE_ADDR)
                                n_state = i2cm_pkg::ST_B1;
                            else if (r_byte_stage == i2cm_pkg::STAGE_REG)
                                n_state = r_is_read ? i2cm_pkg::ST_S1 : i2cm_pkg::ST_B1;
                            else if (r_is_read && (r_bytes_left != '0))
                                n_state = i2cm_pkg::ST_R1;
                            else
                                n_state = i2cm_pkg::ST_P0;
                        end
                        i2cm_pkg::ST_R1: n_state = i2cm_pkg::ST_R2;
                        i2cm_pkg::ST_R2: n_state = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                                                   i2cm_pkg::ST_K1 : i2cm_pkg::ST_R1;
                        i2cm_pkg::ST_K1: n_state = i2cm_pkg::ST_K2;
                        i2cm_pkg::ST_K2: n_state = i2cm_pkg::ST_K3;
                        i2cm_pkg::ST_K3: n_state = (bytes_dec == '0) ?
                                                   i2cm_pkg::ST_P0 : i2cm_pkg::ST_R1;
                        i2cm_pkg::ST_P0: n_state = i2cm_pkg::ST_P1;
                        default:         n_state = i2cm_pkg::ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Datapath and result for this tick
    always_comb begin
        n_phase_count = r_phase_count;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_bytes_left  = r_bytes_left;
        n_ack_wait    = r_ack_wait;
        n_held_addr   = r_held_addr;
        n_held_reg    = r_held_reg;
        n_held_wdata  = r_held_wdata;
        n_is_read     = r_is_read;
        n_held_status = r_held_status;
        n_byte_stage  = r_byte_stage;
        n_scl         = r_scl;
        n_sda         = r_sda;
        o_res         = '0;

        // Advance the phase counter, clear it on every state change
        if (n_state != r_state)
            n_phase_count = '0;
        else if (timed)
            n_phase_count = phase_inc;

        case (r_state)
            i2cm_pkg::ST_IDLE: begin
                if (is_cmd) begin
                    n_held_addr   = i_item.dev_addr;
                    n_held_reg    = i_item.reg_addr;
                    n_held_wdata  = i_item.write_data;
                    n_bytes_left  = i_item.read_len;
                    n_is_read     = (i_item.mode == i2cm_pkg::MODE_READ);
                    n_held_status = i2cm_pkg::STATUS_OK;
                    n_byte_stage  = i2cm_pkg::STAGE_ADDR;
                    n_bit_count   = '0;
                    n_shift       = '0;
                    n_ack_wait    = '0;
                    n_scl         = 1'b1;
                    n_sda         = 1'b1;
                end
            end
            i2cm_pkg::ST_AW: begin
                if (ack_low) begin
                    n_scl = 1'b0;
                end else if (ack_expired) begin
                    n_held_status = i2cm_pkg::STAT_W'(r_byte_stage + 2'd1);
                    n_scl         = 1'b0;
                end else begin
                    n_ack_wait = r_ack_wait + i2cm_pkg::ACKTO_W'(1);
                end
            end
            default: begin
                if (phase_hit) begin
                    case (r_state)
                        i2cm_pkg::ST_S1: n_sda = 1'b0;
                        i2cm_pkg::ST_S2: n_scl = 1'b0;
                        i2cm_pkg::ST_S3: begin
                            n_shift     = tx_byte(r_byte_stage, r_is_read, r_held_addr,
                                                  r_held_reg, r_held_wdata);
                            n_bit_count = '0;
                            n_sda       = n_shift[i2cm_pkg::BYTE_W-1];
                        end
                        i2cm_pkg::ST_B1: n_scl = 1'b1;
                        i2cm_pkg::ST_B2: begin
                            n_scl = 1'b0;
                            if (r_bit_count == i2cm_pkg::LAST_BIT)
                                n_sda = 1'b1;
                        end
                        i2cm_pkg::ST_B3: begin
                            n_shift     = {r_shift[i2cm_pkg::BYTE_W-2:0], 1'b0};
                            n_bit_count = bit_inc;
                            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE)
                                n_sda = 1'b1;
                            else
                                n_sda = n_shift[i2cm_pkg::BYTE_W-1];
                        end
                        i2cm_pkg::ST_A1: n_scl = 1'b1;
                        i2cm_pkg::ST_A2: n_ack_wait = '0;
                        i2cm_pkg::ST_A3: begin
                            if (r_held_status != i2cm_pkg::STATUS_OK) begin
                                n_sda = 1'b0;
                            end else if (r_byte_stage == i2cm_pkg::STAGE_ADDR) begin
                                n_byte_stage = i2cm_pkg::STAGE_REG;
                                n_shift      = tx_byte(i2cm_pkg::STAGE_REG, r_is_read,
                                                       r_held_addr, r_held_reg, r_held_wdata);
                                n_bit_count  = '0;
                                n_sda        = n_shift[i2cm_pkg::BYTE_W-1];
                            end else if (r_byte_stage == i2cm_pkg::STAGE_REG) begin
                                n_byte_stage = i2cm_pkg::STAGE_DATA;
                                if (r_is_read) begin
                                    // repeated start
                                    n_scl = 1'b1;
                                    n_sda = 1'b1;
                                end else begin
                                    n_shift     = tx_byte(i2cm_pkg::STAGE_DATA, r_is_read,
                                                          r_held_addr, r_held_reg,
                                                          r_held_wdata);
                                    n_bit_count = '0;
                                    n_sda       = n_shift[i2cm_pkg::BYTE_W-1];
                                end
                            end else if (r_is_read && (r_bytes_left != '0)) begin
                                n_bit_count = '0;
                                n_shift     = '0;
                                n_sda       = 1'b1;
                                n_scl       = 1'b1;
                            end else begin
                                n_sda = 1'b0;
                            end
                        end
                        i2cm_pkg::ST_R1: begin
                            n_shift = {r_shift[i2cm_pkg::BYTE_W-2:0], i_item.sda_in};
                            n_scl   = 1'b0;
                        end
                        i2cm_pkg::ST_R2: begin
                            n_bit_count = bit_inc;
                            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                                o_res.rx_valid = 1'b1;
                                o_res.rx_data  = r_shift;
                                o_res.rx_last  = (r_bytes_left == i2cm_pkg::BYTE_W'(1));
                                // NACK the last byte, ACK the rest
                                n_sda          = o_res.rx_last;
                            end else begin
                                n_scl = 1'b1;
                            end
                        end
                        i2cm_pkg::ST_K1: n_scl = 1'b1;
                        i2cm_pkg::ST_K2: n_scl = 1'b0;
                        i2cm_pkg::ST_K3: begin
                            n_bytes_left = bytes_dec;
                            if (bytes_dec == '0) begin
                                n_sda = 1'b0;
                            end else begin
                                n_bit_count = '0;
                                n_shift     = '0;
                                n_sda       = 1'b1;
                                n_scl       = 1'b1;
                            end
                        end
                        i2cm_pkg::ST_P0: n_scl = 1'b1;
                        i2cm_pkg::ST_P1: begin
                            n_sda          = 1'b1;
                            o_res.done_res = 1'b1;
                            o_res.status   = r_held_status;
                        end
                        default: ;
                    endcase
                end
            end
        endcase

        o_res.scl_out  = n_scl;
        o_res.sda_out  = n_sda;
        o_res.busy_res = (n_state != i2cm_pkg::ST_IDLE);
    end

    // Hold sequencer control state, advance on each stepped tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= i2cm_pkg::ST_IDLE;
            r_phase_count <= '0;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_bytes_left  <= '0;
            r_ack_wait    <= '0;
            r_is_read     <= 1'b0;
            r_held_status <= i2cm_pkg::STATUS_OK;
            r_byte_stage  <= i2cm_pkg::STAGE_ADDR;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
        end else if (i_step) begin
            r_state       <= n_state;
            r_phase_count <= n_phase_count;
            r_bit_count   <= n_bit_count;
            r_shift       <= n_shift;
            r_bytes_left  <= n_bytes_left;
            r_ack_wait    <= n_ack_wait;
            r_is_read     <= n_is_read;
            r_held_status <= n_held_status;
            r_byte_stage  <= n_byte_stage;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
        end
    end

    // Hold the command bytes, written when a command starts
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_held_addr  <= n_held_addr;
            r_held_reg   <= n_held_reg;
            r_held_wdata <= n_held_wdata;
        end
    end

`ifndef NO_ASSERTIONS
    // A completed stop always returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_state == i2cm_pkg::ST_IDLE))
        else $error("sequencer not idle after stop");

    // A received byte is only reported from the receive low phase
    a_rx_from_r2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.rx_valid |-> (r_state == i2cm_pkg::ST_R2))
        else $error("byte reported outside receive phase");

    // Nonzero status only travels with the done flag
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.status != i2cm_pkg::STATUS_OK) |-> o_res.done_res)
        else $error("status without completion");

    // Bit counter never runs past one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= i2cm_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");
`endif

endmodule
`default_nettype wire

/* sv/i2c_master_register_access_core.sv */
// Top level: handshake registers, configuration registers and the bus sequencer.
`default_nettype none
// I2C master register access core. Every input item is one bus tick and yields
// exactly one result item: the SCL and SDA levels after that tick, the busy
// flag, any byte received on it and, on the tick the stop completes, the done
// flag and status. One item is taken every clock while o_in_stall is low; a
// result is registered: the item passes the input register, then the
// single-step sequencer logic into the result register. The result register
// decouples the two sides, so a new item can be taken into the empty input
// register while a finished result still waits. Write phase_ticks (index 0)
// and ack_timeout (index 1) only while no transaction is running.
module i2c_master_register_access_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [i2cm_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [i2cm_pkg::BYTE_W-1:0]       i_dev_addr,
    input  wire logic [i2cm_pkg::BYTE_W-1:0]       i_reg_addr,
    input  wire logic [i2cm_pkg::BYTE_W-1:0]       i_write_data,
    input  wire logic [i2cm_pkg::BYTE_W-1:0]       i_read_len,
    input  wire logic                              i_sda_in,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_scl_out,
    output logic                                   o_sda_out,
    output logic                                   o_busy_res,
    output logic                                   o_rx_valid,
    output logic [i2cm_pkg::BYTE_W-1:0]            o_rx_data,
    output logic                                   o_rx_last,
    output logic                                   o_done_res,
    output logic [i2cm_pkg::STAT_W-1:0]            o_status,
    // configuration write port
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [i2cm_pkg::CFGIDX_W-1:0]     i_cfg_index,
    input  wire logic [i2cm_pkg::CFGDAT_W-1:0]     i_cfg_data
);

    logic              r_in_valid;
    i2cm_pkg::t_item   r_item;
    logic              r_out_valid;
    i2cm_pkg::t_result r_res;
    i2cm_pkg::t_result seq_res;
    i2cm_pkg::t_cfg    r_cfg;
    logic              out_free;
    logic              step;
    logic              in_take;

    // Flow control between the two register stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Hold the input valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else if (in_take)
            r_in_valid <= 1'b1;
        else if (step)
            r_in_valid <= 1'b0;
    end

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.mode       <= i_mode;
            r_item.dev_addr   <= i_dev_addr;
            r_item.reg_addr   <= i_reg_addr;
            r_item.write_data <= i_write_data;
            r_item.read_len   <= i_read_len;
            r_item.sda_in     <= i_sda_in;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
            r_cfg.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                i2cm_pkg::CFG_PHASE_TICKS:
                    r_cfg.phase_ticks <= i_cfg_data[i2cm_pkg::PHASE_W-1:0];
                i2cm_pkg::CFG_ACK_TIMEOUT:
                    r_cfg.ack_timeout <= i_cfg_data[i2cm_pkg::ACKTO_W-1:0];
                default: ;
            endcase
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    // Advance the result register when it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (out_free)
            r_out_valid <= r_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (step)
            r_res <= seq_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_res.scl_out;
    assign o_sda_out   = r_res.sda_out;
    assign o_busy_res  = r_res.busy_res;
    assign o_rx_valid  = r_res.rx_valid;
    assign o_rx_data   = r_res.rx_data;
    assign o_rx_last   = r_res.rx_last;
    assign o_done_res  = r_res.done_res;
    assign o_status    = r_res.status;

endmodule
`default_nettype wire
